### rtl/core/clope_pkg.sv
// Shared types, constants and the root table for the CLOPE cluster core.
package clope_pkg;

    localparam int OBJ_W     = 12;
    localparam int KIND_W    = 2;
    localparam int REP_W     = 15;
    localparam int WIDTH_W   = 13;
    localparam int SIZE_W    = 32;
    localparam int COUNT_W   = 16;
    localparam int NCOUNT_W  = 17;   // count + 1 for evaluate add
    localparam int DELTA_W   = 64;
    localparam int OCC_W     = 16;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 128;
    localparam int PROD_W    = 49;   // size * count
    localparam int ROOTS     = 16;

    localparam logic [WIDTH_W-1:0] LIM13    = 13'd8191;
    localparam logic [OCC_W-1:0]   OCC_MAX  = 16'hFFFF;
    localparam logic [DELTA_W-1:0] SAT63    = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef enum logic [1:0] {
        KIND_ADD,
        KIND_REMOVE,
        KIND_EVAL_ADD,
        KIND_EVAL_REMOVE
    } kind_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ITEM,
        ST_FINISH,
        ST_TERM_A,
        ST_WAIT_A,
        ST_TERM_B,
        ST_WAIT_B,
        ST_EMIT
    } core_state_t;

    typedef enum logic [2:0] {
        T_IDLE,
        T_LOG,
        T_EXP,
        T_ROOT,
        T_DIV_SETUP,
        T_DIV
    } term_state_t;

    typedef struct packed {
        logic                start;
        logic [SIZE_W-1:0]   size;
        logic [NCOUNT_W-1:0] count;
        logic [WIDTH_W-1:0]  width;
    } term_req_t;

    typedef struct packed {
        logic               done;
        logic [DELTA_W-1:0] value;
    } term_rsp_t;

    // 2^(2^-k) in Q1.30 for k = 1..16, each the floor root of the one before
    typedef logic [ROOTS-1:0][30:0] root_tab_t;

    function automatic root_tab_t build_roots();
        root_tab_t   tab;
        logic [63:0] root;
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        root = 64'd1 << 31;
        for (int k = 0; k < ROOTS; k++) begin
            x = root << 30;
            r = 64'd0;
            b = 64'd1 << 62;
            for (int i = 0; i < 32; i++) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
            root   = r;
            tab[k] = root[30:0];
        end
        return tab;
    endfunction

endpackage

### rtl/core/clope_term_unit.sv
// Iterative evaluator of one cluster term S*N / W^r in Q.8, saturating.
module clope_term_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic [clope_pkg::REP_W-1:0]   repulsion,
    input  clope_pkg::term_req_t          req,
    output clope_pkg::term_rsp_t          rsp
);
    import clope_pkg::*;

    localparam root_tab_t ROOT_TAB = build_roots();

    term_state_t          state_reg, state_next;
    logic [PROD_W-1:0]    p_reg;
    logic [3:0]           msb_reg;
    logic [30:0]          m_reg;
    logic [15:0]          frac_reg;
    logic [6:0]           step_reg;
    logic [22:0]          e_reg;
    logic [30:0]          g_reg;
    logic [PROD_W-1:0]    src_reg;
    logic [6:0]           steps_reg;
    logic [31:0]          rem_reg;
    logic [DELTA_W-1:0]   q_reg;
    logic                 ov_reg;
    logic                 done_reg;
    logic [DELTA_W-1:0]   value_reg;

    logic                 is_zero;
    logic [3:0]           msb;
    logic [30:0]          m_init;
    logic [61:0]          m_sq;
    logic [31:0]          m_new;
    logic [34:0]          e_prod;
    logic [61:0]          g_prod;
    logic [6:0]           eint;
    logic [6:0]           rshift;
    logic [31:0]          rem_sh;
    logic                 q_bit;
    logic [31:0]          rem_new;
    logic [DELTA_W-1:0]   q_new;
    logic                 ov_new;
    logic                 div_last;

    assign is_zero = (req.size == '0) || (req.count == '0) || (req.width == '0);

    always_comb begin
        msb = 4'd0;
        for (int i = 0; i < WIDTH_W; i++) begin
            if (req.width[i]) msb = 4'(i);
        end
    end

    assign m_init = 31'(req.width) << (5'd30 - 5'(msb));
    assign m_sq   = 62'(m_reg) * 62'(m_reg);
    assign m_new  = m_sq[61:30];
    assign e_prod = 35'(repulsion) * 35'({msb_reg, frac_reg}) + 35'd2048;
    assign g_prod = 62'(g_reg) * 62'(ROOT_TAB[step_reg[3:0]]);

    assign eint   = e_reg[22:16];
    assign rshift = eint - 7'd38;

    // one restoring division step
    assign rem_sh  = {rem_reg[30:0], src_reg[PROD_W-1]};
    assign q_bit   = rem_sh >= 32'(g_reg);
    assign rem_new = q_bit ? rem_sh - 32'(g_reg) : rem_sh;
    assign q_new   = {q_reg[DELTA_W-2:0], q_bit};
    assign ov_new  = ov_reg | q_reg[DELTA_W-1];
    assign div_last = step_reg == steps_reg - 7'd1;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            T_IDLE:      if (req.start && !is_zero) state_next = T_LOG;
            T_LOG:       if (step_reg[3:0] == 4'd15) state_next = T_EXP;
            T_EXP:       state_next = T_ROOT;
            T_ROOT:      if (step_reg[3:0] == 4'd15) state_next = T_DIV_SETUP;
            T_DIV_SETUP: state_next = T_DIV;
            T_DIV:       if (div_last) state_next = T_IDLE;
            default:     state_next = T_IDLE;
        endcase
    end

    always_comb begin
        rsp.done  = done_reg;
        rsp.value = value_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= T_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= ((state_reg == T_IDLE) && req.start && is_zero) ||
                         ((state_reg == T_DIV) && div_last);
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            T_IDLE: begin
                p_reg    <= PROD_W'(req.size) * PROD_W'(req.count);
                m_reg    <= m_init;
                msb_reg  <= msb;
                frac_reg <= '0;
                step_reg <= '0;
                if (req.start && is_zero) value_reg <= '0;
            end
            T_LOG: begin
                frac_reg <= {frac_reg[14:0], m_new[31]};
                m_reg    <= m_new[31] ? m_new[31:1] : m_new[30:0];
                step_reg <= step_reg + 7'd1;
            end
            T_EXP: begin
                e_reg    <= e_prod[34:12];
                g_reg    <= 31'h4000_0000;
                step_reg <= '0;
            end
            T_ROOT: begin
                if (e_reg[4'd15 - step_reg[3:0]]) g_reg <= g_prod[60:30];
                step_reg <= step_reg + 7'd1;
            end
            T_DIV_SETUP: begin
                if (eint <= 7'd38) begin
                    src_reg   <= p_reg;
                    steps_reg <= 7'd87 - eint;
                end else begin
                    src_reg   <= (rshift > 7'd48) ? '0 : p_reg >> rshift[5:0];
                    steps_reg <= 7'd49;
                end
                rem_reg  <= '0;
                q_reg    <= '0;
                ov_reg   <= 1'b0;
                step_reg <= '0;
            end
            T_DIV: begin
                src_reg  <= src_reg << 1;
                rem_reg  <= rem_new;
                q_reg    <= q_new;
                ov_reg   <= ov_new;
                step_reg <= step_reg + 7'd1;
                if (div_last) value_reg <= (ov_new || q_new[DELTA_W-1]) ? SAT63 : q_new;
            end
            default: ;
        endcase
    end

endmodule

### rtl/core/clope_cluster_profit_core.sv
// Top level of the CLOPE single-cluster core: count memory, transaction control, profit delta.
//
// Holds one CLOPE cluster: a 16-bit occurrence count per object in an on-chip
// memory plus the cluster width, size and transaction count. A transaction
// streams in one object word at a time on the s_ side; tuser carries the
// kind (add, remove, evaluate add, evaluate remove) and the kind of the
// first word governs the whole transaction; tlast ends it. Each object word
// is taken in ST_IDLE, where its count is read from the memory, and is
// modified and written back in ST_ITEM, so s_tready is low in the write
// cycle. After the last word, add and remove pass through ST_FINISH to
// ST_EMIT. For the evaluate kinds the core runs the term unit twice (new and
// old cluster); each run gives zero directly for an empty cluster, else it
// steps through start, log, exp and root iterations, a division setup and a
// bit-serial division. One result word per transaction leaves on the m_
// side from an output register; object words of the next transaction are
// taken while that word waits. After reset the count memory is cleared one
// entry per cycle, with s_tready low; the cfg port is open throughout and
// should be written only while no transaction is open.
module clope_cluster_profit_core #(
    parameter int unsigned   NUM_OBJECTS      = 4096,
    parameter logic [31:0]   MAX_TRANSACTIONS = 32'd65535
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input stream
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [clope_pkg::S_TDATA_W-1:0]   s_tdata,   // [11:0] object_index
    input  logic [clope_pkg::KIND_W-1:0]      s_tuser,   // [1:0] kind
    input  logic                              s_tlast,   // last_item
    // result stream
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [63:0] profit_delta, [76:64] cluster_width, [108:77] cluster_size,
    // [124:109] transaction_count
    output logic [clope_pkg::M_TDATA_W-1:0]   m_tdata,
    // repulsion register
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [clope_pkg::REP_W-1:0]       cfg_data   // repulsion, Q3.12
);
    import clope_pkg::*;

    localparam int AW = $clog2(NUM_OBJECTS);
    localparam logic [AW:0] LAST_ADDR = (AW+1)'(NUM_OBJECTS - 1);
    localparam logic [COUNT_W-1:0] COUNT_CAP =
        (MAX_TRANSACTIONS > 32'd65535) ? 16'hFFFF : MAX_TRANSACTIONS[COUNT_W-1:0];

    // occurrence count memory, one read and one write port
    logic [OCC_W-1:0] occ_mem [NUM_OBJECTS];
    logic [OCC_W-1:0] rd_data_reg;
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [OCC_W-1:0] mem_wdata;

    core_state_t        state_reg, state_next;
    logic [AW:0]        clr_cnt_reg;
    kind_t              held_kind_reg;
    logic               busy_reg;
    logic               last_reg;
    logic               in_range_reg;
    logic [AW-1:0]      waddr_reg;
    logic [WIDTH_W-1:0] width_reg;
    logic [SIZE_W-1:0]  size_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [WIDTH_W-1:0] run_len_reg;
    logic [WIDTH_W-1:0] run_wchg_reg;
    logic [REP_W-1:0]   rep_reg;
    logic [WIDTH_W-1:0] new_w_reg;
    logic [SIZE_W-1:0]  new_s_reg;
    logic [NCOUNT_W-1:0] new_n_reg;
    logic [DELTA_W-1:0] term_a_reg;
    logic [DELTA_W-1:0] delta_reg;
    logic               m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;

    logic [16:0]        obj_ext;
    logic               s_accept;
    logic               out_free;
    logic               hit;
    logic               grow;
    logic               is_eval;
    logic [WIDTH_W:0]   w_sum;
    logic [SIZE_W:0]    s_sum;
    logic [WIDTH_W-1:0] nw;
    logic [SIZE_W-1:0]  ns;
    logic [NCOUNT_W-1:0] nn;
    term_req_t          term_req;
    term_rsp_t          term_rsp;

    assign obj_ext   = 17'(s_tdata[OBJ_W-1:0]);
    assign s_accept  = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign grow    = (held_kind_reg == KIND_ADD) || (held_kind_reg == KIND_EVAL_ADD);
    assign is_eval = (held_kind_reg == KIND_EVAL_ADD) || (held_kind_reg == KIND_EVAL_REMOVE);

    // width-change hit for the word in the modify cycle
    always_comb begin
        unique case (held_kind_reg)
            KIND_ADD:         hit = rd_data_reg == '0;
            KIND_REMOVE:      hit = rd_data_reg == OCC_W'(1);
            KIND_EVAL_ADD:    hit = rd_data_reg == '0;
            KIND_EVAL_REMOVE: hit = rd_data_reg == OCC_W'(1);
            default:          hit = 1'b0;
        endcase
    end

    // cluster figures after the transaction
    assign w_sum = 14'(width_reg) + 14'(run_wchg_reg);
    assign s_sum = 33'(size_reg) + 33'(run_len_reg);
    always_comb begin
        if (grow) begin
            nw = w_sum[WIDTH_W] ? LIM13 : w_sum[WIDTH_W-1:0];
            ns = s_sum[SIZE_W] ? '1 : s_sum[SIZE_W-1:0];
            nn = 17'(count_reg) + 17'd1;
        end else begin
            nw = (width_reg > run_wchg_reg) ? width_reg - run_wchg_reg : '0;
            ns = (size_reg > 32'(run_len_reg)) ? size_reg - 32'(run_len_reg) : '0;
            nn = (count_reg != '0) ? 17'(count_reg - 16'd1) : '0;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:  if (clr_cnt_reg == LAST_ADDR) state_next = ST_IDLE;
            ST_IDLE:   if (s_tvalid) state_next = ST_ITEM;
            ST_ITEM:   state_next = last_reg ? ST_FINISH : ST_IDLE;
            ST_FINISH: state_next = is_eval ? ST_TERM_A : ST_EMIT;
            ST_TERM_A: state_next = ST_WAIT_A;
            ST_WAIT_A: if (term_rsp.done) state_next = ST_TERM_B;
            ST_TERM_B: state_next = ST_WAIT_B;
            ST_WAIT_B: if (term_rsp.done) state_next = ST_EMIT;
            ST_EMIT:   if (out_free) state_next = ST_IDLE;
            default:   state_next = ST_CLEAR;
        endcase
    end

    // control outputs
    always_comb begin
        s_tready       = state_reg == ST_IDLE;
        mem_we         = 1'b0;
        mem_waddr      = waddr_reg;
        mem_wdata      = rd_data_reg;
        term_req.start = 1'b0;
        term_req.size  = new_s_reg;
        term_req.count = new_n_reg;
        term_req.width = new_w_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = clr_cnt_reg[AW-1:0];
                mem_wdata = '0;
            end
            ST_ITEM: begin
                if (held_kind_reg == KIND_ADD) begin
                    mem_we    = in_range_reg && (rd_data_reg != OCC_MAX);
                    mem_wdata = rd_data_reg + OCC_W'(1);
                end else if (held_kind_reg == KIND_REMOVE) begin
                    mem_we    = in_range_reg && (rd_data_reg != '0);
                    mem_wdata = rd_data_reg - OCC_W'(1);
                end
            end
            ST_TERM_A: term_req.start = 1'b1;
            ST_TERM_B: begin
                term_req.start = 1'b1;
                term_req.size  = size_reg;
                term_req.count = 17'(count_reg);
                term_req.width = width_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (mem_we) occ_mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= occ_mem[obj_ext[AW-1:0]];
    end

    clope_term_unit u_term (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .repulsion (rep_reg),
        .req       (term_req),
        .rsp       (term_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            held_kind_reg <= KIND_ADD;
            busy_reg      <= 1'b0;
            width_reg     <= '0;
            size_reg      <= '0;
            count_reg     <= '0;
            run_len_reg   <= '0;
            run_wchg_reg  <= '0;
            rep_reg       <= 15'd4096;
            m_tvalid_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) rep_reg <= cfg_data;
            // a new word loads the output register, else a taken word frees it
            if ((state_reg == ST_EMIT) && out_free) m_tvalid_reg <= 1'b1;
            else if (m_tvalid_reg && m_tready) m_tvalid_reg <= 1'b0;

            unique case (state_reg)
                ST_CLEAR: clr_cnt_reg <= clr_cnt_reg + (AW+1)'(1);
                ST_IDLE: begin
                    if (s_accept) begin
                        if (!busy_reg) held_kind_reg <= kind_t'(s_tuser);
                        busy_reg     <= 1'b1;
                        last_reg     <= s_tlast;
                        in_range_reg <= obj_ext < 17'(NUM_OBJECTS);
                        waddr_reg    <= obj_ext[AW-1:0];
                    end
                end
                ST_ITEM: begin
                    if (in_range_reg) begin
                        if (run_len_reg != LIM13) run_len_reg <= run_len_reg + 13'd1;
                        if (hit && run_wchg_reg != LIM13) run_wchg_reg <= run_wchg_reg + 13'd1;
                    end
                end
                ST_FINISH: begin
                    new_w_reg <= nw;
                    new_s_reg <= ns;
                    new_n_reg <= nn;
                    delta_reg <= '0;
                    if (held_kind_reg == KIND_ADD) begin
                        width_reg <= nw;
                        size_reg  <= ns;
                        if (count_reg < COUNT_CAP) count_reg <= count_reg + 16'd1;
                    end else if (held_kind_reg == KIND_REMOVE) begin
                        width_reg <= nw;
                        size_reg  <= ns;
                        count_reg <= nn[COUNT_W-1:0];
                    end
                end
                ST_WAIT_A: if (term_rsp.done) term_a_reg <= term_rsp.value;
                ST_WAIT_B: begin
                    if (term_rsp.done) begin
                        // term A is the new cluster, term B the old one
                        delta_reg <= (held_kind_reg == KIND_EVAL_ADD)
                                   ? term_a_reg - term_rsp.value
                                   : term_rsp.value - term_a_reg;
                    end
                end
                ST_EMIT: begin
                    if (out_free) begin
                        m_tdata_reg  <= {3'b000, count_reg, size_reg, width_reg, delta_reg};
                        run_len_reg  <= '0;
                        run_wchg_reg <= '0;
                        busy_reg     <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

### tb/sv/tb_clope_cluster_profit_core.sv
// Self-checking testbench for the CLOPE single-cluster core: directed table, then random transactions.
module tb_clope_cluster_profit_core;
    timeunit 1ns;
    timeprecision 1ps;
    import clope_pkg::*;

    localparam int NOBJ        = 4096;
    localparam int SETTLE      = 600;     // covers the slowest evaluate tail
    localparam int STALL_LIMIT = 20000;   // idle cycles before the run is declared hung
    localparam int RANDOM_WORDS = 1850;
    localparam int PHASES      = 8;

    typedef struct {
        logic [DELTA_W-1:0] delta;
        logic [WIDTH_W-1:0] width;
        logic [SIZE_W-1:0]  size;
        logic [COUNT_W-1:0] count;
    } cluster_result_t;

    typedef struct {
        kind_t             kind;
        logic [OBJ_W-1:0]  obj;
        bit                last;
        bit                typed;
        cluster_result_t   res;
    } stim_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [KIND_W-1:0]    s_tuser = '0;
    logic                 s_tlast = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [REP_W-1:0]     cfg_data = '0;

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    clope_cluster_profit_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // ---------------------------------------------------------------
    // Cluster predictor: own copy of counts, totals and repulsion
    // ---------------------------------------------------------------
    logic [OCC_W-1:0]   occ [NOBJ];
    logic [WIDTH_W-1:0] clu_width;
    logic [SIZE_W-1:0]  clu_size;
    logic [COUNT_W-1:0] clu_count;
    logic [WIDTH_W-1:0] run_len;
    logic [WIDTH_W-1:0] run_wchg;
    logic [REP_W-1:0]   rep_val;
    bit                 in_txn;
    kind_t              txn_kind;

    cluster_result_t    pending_results[$];
    int                 fail_count = 0;

    function automatic logic [63:0] isqrt_floor(logic [63:0] x);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // log2 in Q4.16 by repeated squaring of the Q1.30 mantissa
    function automatic logic [63:0] log2_fix(logic [31:0] w);
        int unsigned n;
        logic [63:0] m;
        logic [63:0] frac;
        n = 0;
        frac = 0;
        while (n < 31 && (w >> (n + 1)) != 0) n++;
        m = 64'(w) << (30 - n);
        for (int i = 0; i < 16; i++) begin
            m = (m * m) >> 30;
            frac = frac << 1;
            if (m >= (64'd1 << 31)) begin
                m = m >> 1;
                frac[0] = 1'b1;
            end
        end
        return (64'(n) << 16) | frac;
    endfunction

    // S*N / W^r in Q.8, truncated and saturated
    function automatic logic [63:0] profit_term(logic [31:0] s, logic [31:0] n,
                                                logic [31:0] w);
        logic [63:0] p, e, g, root, q, rem;
        int          eint;
        int          shift;
        if (s == 0 || n == 0 || w == 0) return 64'd0;
        if (w > 8191) w = 8191;
        p = 64'(s) * 64'(n);
        e = (64'(rep_val) * log2_fix(w) + 64'd2048) >> 12;
        eint = int'(e >> 16);
        g = 64'd1 << 30;
        root = 64'd1 << 31;
        for (int k = 1; k <= 16; k++) begin
            root = isqrt_floor(root << 30);
            if (e[16-k]) g = (g * root) >> 30;
        end
        q = p / g;
        rem = p % g;
        shift = 38 - eint;
        if (shift < 0) begin
            if (shift <= -64) return 64'd0;
            return q >> (-shift);
        end
        while (shift > 0) begin
            shift--;
            if (q >= (64'd1 << 62)) return SAT63;
            q = q << 1;
            rem = rem << 1;
            if (rem >= g) begin
                rem = rem - g;
                q = q + 1;
            end
        end
        return (q > SAT63) ? SAT63 : q;
    endfunction

    function automatic void cluster_reset();
        foreach (occ[i]) occ[i] = '0;
        clu_width = '0; clu_size = '0; clu_count = '0;
        run_len = '0; run_wchg = '0;
        rep_val = 15'd4096;
        in_txn = 0;
        txn_kind = KIND_ADD;
    endfunction

    // one accepted word; returns 1 with the result when it closes a transaction
    function automatic bit cluster_step(kind_t kind, logic [OBJ_W-1:0] obj, bit last,
                                        output cluster_result_t res);
        logic [OCC_W-1:0] c;
        logic [31:0]      nw, ns, nn;
        bit               hit;
        hit = 0;
        res = '{default: '0};
        if (!in_txn) begin
            txn_kind = kind;
            in_txn = 1;
        end
        if (run_len < LIM13) run_len++;
        c = occ[obj];
        case (txn_kind)
            KIND_ADD: begin
                hit = (c == 0);
                if (c < OCC_MAX) occ[obj] = c + 1'b1;
            end
            KIND_REMOVE: begin
                if (c > 0) begin
                    occ[obj] = c - 1'b1;
                    hit = (c == 1);
                end
            end
            KIND_EVAL_ADD: hit = (c == 0);
            default:       hit = (c == 1);
        endcase
        if (hit && run_wchg < LIM13) run_wchg++;
        if (!last) return 0;

        if (txn_kind == KIND_ADD || txn_kind == KIND_EVAL_ADD) begin
            nw = 32'(clu_width) + 32'(run_wchg);
            if (nw > 8191) nw = 8191;
            ns = (clu_size > 32'hFFFF_FFFF - 32'(run_len)) ? 32'hFFFF_FFFF
                                                          : clu_size + 32'(run_len);
            nn = 32'(clu_count) + 1;
        end else begin
            nw = (clu_width > run_wchg) ? 32'(clu_width - run_wchg) : 0;
            ns = (clu_size > 32'(run_len)) ? clu_size - 32'(run_len) : 0;
            nn = (clu_count > 0) ? 32'(clu_count) - 1 : 0;
        end
        case (txn_kind)
            KIND_ADD: begin
                clu_width = nw[WIDTH_W-1:0];
                clu_size  = ns;
                if (clu_count < 16'hFFFF) clu_count++;
            end
            KIND_REMOVE: begin
                clu_width = nw[WIDTH_W-1:0];
                clu_size  = ns;
                clu_count = nn[COUNT_W-1:0];
            end
            KIND_EVAL_ADD:
                res.delta = profit_term(ns, nn, nw) - profit_term(clu_size, clu_count, clu_width);
            default:
                res.delta = profit_term(clu_size, clu_count, clu_width) - profit_term(ns, nn, nw);
        endcase
        run_len = '0;
        run_wchg = '0;
        in_txn = 0;
        res.width = clu_width;
        res.size  = clu_size;
        res.count = clu_count;
        return 1;
    endfunction

    // ---------------------------------------------------------------
    // Result side: stall pattern and checker
    // ---------------------------------------------------------------
    int unsigned recv_mode = 0;
    int unsigned recv_tick = 0;

    // receiver alternates between always ready, coin flips and a 1-in-8 trickle
    always @(posedge aclk) begin
        recv_tick <= recv_tick + 1;
        if (recv_tick % 128 == 0) recv_mode <= $urandom_range(0, 2);
        case (recv_mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= $urandom_range(0, 1);
            default: m_tready <= (recv_tick % 8 == 0);
        endcase
    end

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        cluster_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result word with nothing expected");
            end else begin
                want = pending_results.pop_front();
                if (m_tdata[63:0] !== want.delta)
                    report_mismatch($sformatf("profit_delta %0d, want %0d",
                        $signed(m_tdata[63:0]), $signed(want.delta)));
                if (m_tdata[76:64] !== want.width)
                    report_mismatch($sformatf("cluster_width %0d, want %0d",
                        m_tdata[76:64], want.width));
                if (m_tdata[108:77] !== want.size)
                    report_mismatch($sformatf("cluster_size %0d, want %0d",
                        m_tdata[108:77], want.size));
                if (m_tdata[124:109] !== want.count)
                    report_mismatch($sformatf("transaction_count %0d, want %0d",
                        m_tdata[124:109], want.count));
            end
        end
    end

    // watchdog: cycles in a row without any handshake
    int unsigned quiet_cycles = 0;
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > STALL_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Input side: bursty sender
    // ---------------------------------------------------------------
    int unsigned burst_left = 1;
    bit          valid_dropped = 1;

    task automatic send_word(kind_t kind, logic [OBJ_W-1:0] obj, bit last,
                             bit typed = 0, cluster_result_t typed_res = '{default: '0});
        cluster_result_t r;
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(obj);
        s_tuser  <= kind;
        s_tlast  <= last;
        valid_dropped = 0;
        do @(posedge aclk); while (!s_tready);
        if (cluster_step(kind, obj, last, r))
            pending_results.push_back(typed ? typed_res : r);
        burst_left--;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            valid_dropped = 1;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 30);
        end
    endtask

    // quiet the sender, drain every result and let any tail finish
    task automatic drain_all();
        if (!valid_dropped) begin
            s_tvalid <= 1'b0;
            valid_dropped = 1;
        end
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_repulsion(logic [REP_W-1:0] v);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        rep_val = v;
    endtask

    // one random transaction; small object pool so counts build up
    task automatic random_transaction(output int words);
        int    len;
        kind_t k;
        logic [OBJ_W-1:0] obj;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: k = KIND_ADD;
            4, 5:       k = KIND_REMOVE;
            6, 7:       k = KIND_EVAL_ADD;
            default:    k = KIND_EVAL_REMOVE;
        endcase
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        for (int i = 0; i < len; i++) begin
            obj = ($urandom_range(0, 4) == 0) ? OBJ_W'($urandom) : OBJ_W'($urandom_range(0, 63));
            // later words sometimes carry a stray kind, which must be ignored
            send_word((i > 0 && $urandom_range(0, 9) == 0) ? kind_t'($urandom_range(0, 3)) : k,
                      obj, i == len - 1);
        end
        words = len;
    endtask

    // directed rows: typed expectations only where they follow at a glance
    stim_row_t directed[] = '{
        // evaluate add on an empty cluster: W=1, S=N=1 gives 1.0
        '{KIND_EVAL_ADD,    12'd0,    1, 1, '{64'd256, 13'd0, 32'd0, 16'd0}},
        '{KIND_ADD,         12'd0,    0, 0, '{default: '0}},
        '{KIND_ADD,         12'd4095, 1, 1, '{64'd0, 13'd2, 32'd2, 16'd1}},
        '{KIND_EVAL_REMOVE, 12'd0,    1, 0, '{default: '0}},
        '{KIND_EVAL_ADD,    12'd7,    0, 0, '{default: '0}},
        '{KIND_ADD,         12'd4095, 1, 0, '{default: '0}},   // kind ignored mid-transaction
        // removing an absent object: width stays, size and count drop
        '{KIND_REMOVE,      12'd9,    1, 1, '{64'd0, 13'd2, 32'd1, 16'd0}},
        '{KIND_REMOVE,      12'd0,    0, 0, '{default: '0}},
        '{KIND_REMOVE,      12'd4095, 1, 1, '{64'd0, 13'd0, 32'd0, 16'd0}},
        // empty cluster on both sides
        '{KIND_EVAL_REMOVE, 12'd3,    1, 1, '{64'd0, 13'd0, 32'd0, 16'd0}},
        // duplicate object: only the first occurrence widens
        '{KIND_ADD,         12'd5,    0, 0, '{default: '0}},
        '{KIND_ADD,         12'd5,    1, 1, '{64'd0, 13'd1, 32'd2, 16'd1}},
        '{KIND_ADD,         12'd2730, 0, 0, '{default: '0}},
        '{KIND_ADD,         12'd1365, 1, 0, '{default: '0}},
        '{KIND_EVAL_ADD,    12'd5,    0, 0, '{default: '0}},
        '{KIND_EVAL_ADD,    12'd4000, 1, 0, '{default: '0}},
        '{KIND_EVAL_REMOVE, 12'd5,    0, 0, '{default: '0}},
        '{KIND_REMOVE,      12'd2730, 1, 0, '{default: '0}}
    };

    logic [REP_W-1:0] phase_rep [PHASES] = '{15'd32767, 15'd0, 15'd4096, 15'd1,
                                             15'd8192, 15'd16384, 15'd24575, 15'd6000};

    initial begin
        int words;
        int sent;
        cluster_reset();
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed[i])
            send_word(directed[i].kind, directed[i].obj, directed[i].last,
                      directed[i].typed, directed[i].res);
        drain_all();

        for (int ph = 0; ph < PHASES; ph++) begin
            // a few phases take a fully random exponent
            write_repulsion((ph >= 5 && $urandom_range(0, 1)) ? REP_W'($urandom) : phase_rep[ph]);
            sent = 0;
            while (sent < RANDOM_WORDS / PHASES) begin
                random_transaction(words);
                sent += words;
            end
            drain_all();
        end

        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
